// File: rtl/run_length_encoder_decimal_defines.svh
// ----------------------------------------------------------------------------
// Run-length encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_ENCODER_DECIMAL_DEFINES_SVH
`define RUN_LENGTH_ENCODER_DECIMAL_DEFINES_SVH

// prop must hold at every clock edge out of reset
`define RLED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// when trig holds, conseq must hold in the next cycle
`define RLED_ASSERT_NEXT(label, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (conseq)) \
    else $error(msg);

`endif

// File: rtl/rled_pkg.sv
// ----------------------------------------------------------------------------
// Run-length encoder package
// Widths, item and job types, and BCD helper functions.
// ----------------------------------------------------------------------------
package rled_pkg;

  localparam int RUN_DIGITS  = 5;
  localparam int CNT_W       = 4 * RUN_DIGITS;
  localparam int POS_W       = (RUN_DIGITS > 1) ? $clog2(RUN_DIGITS) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_output;
  } out_item_t;

  // one finished run waiting to be written out
  typedef struct packed {
    logic [7:0]       run_byte;
    logic [CNT_W-1:0] count;
    logic             last_of_item;
    logic             end_of_output;
  } job_t;

  function automatic logic [CNT_W-1:0] bcd_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    logic             c;
    logic [4:0]       s;
    r = '0;
    c = 1'b1;
    for (int i = 0; i < RUN_DIGITS; i++) begin
      s = {1'b0, v[4*i +: 4]} + {4'd0, c};
      if (s > 5'd9) begin
        r[4*i +: 4] = 4'd0;
        c = 1'b1;
      end else begin
        r[4*i +: 4] = s[3:0];
        c = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic bcd_full(input logic [CNT_W-1:0] v);
    logic f;
    f = 1'b1;
    for (int i = 0; i < RUN_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) f = 1'b0;
    end
    return f;
  endfunction

  // position of the most significant nonzero digit, zero if none
  function automatic logic [POS_W-1:0] bcd_top(input logic [CNT_W-1:0] v);
    logic [POS_W-1:0] t;
    t = '0;
    for (int i = 0; i < RUN_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd0) t = POS_W'(i);
    end
    return t;
  endfunction

endpackage

// File: rtl/run_length_encoder_decimal.sv
// ----------------------------------------------------------------------------
// Run-length encoder with decimal run count
// Encodes a byte stream as run byte followed by ASCII decimal count digits.
// ----------------------------------------------------------------------------
// An item that only extends a run gives no result, so such items may come
// every cycle while full is low. Each finished run is put on a four-deep
// job queue; the back end then writes one result per cycle while the output
// is taken (the run byte, then one to RUN_DIGITS count digits, most
// significant first), so a stream of single-byte runs is held back by the
// back end, which writes two results for each. An item that ends two runs
// at once (a new byte on the last position of a string) keeps full high
// while the second run waits in a pending register until the queue takes it.
// Results come from a register and keep flowing while the input side is
// stalled, and the reverse while the job queue has room.
module run_length_encoder_decimal (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  rled_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output rled_pkg::out_item_t out_item
);

  logic           q_push, q_full, q_pop, q_empty;
  rled_pkg::job_t q_data, q_head;

  rled_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (push),
    .in_full (full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full)
  );

  rled_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  rled_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_item  (out_item)
  );

endmodule

// File: rtl/rled_front.sv
// ----------------------------------------------------------------------------
// Run-length encoder front end
// Tracks the open run and its BCD count, and queues each finished run.
// ----------------------------------------------------------------------------
`include "run_length_encoder_decimal_defines.svh"

module rled_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rled_pkg::in_item_t in_item,
  output logic               q_push,
  output rled_pkg::job_t     q_data,
  input  logic               q_full
);

  logic [7:0]                 held_r, held_nxt;
  logic                       open_r, open_nxt;
  logic [rled_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pend_r, pend_nxt;
  rled_pkg::job_t             pend_job_r, pend_job_nxt;

  logic                       accept, ext, emit_old, emit_new;
  logic [rled_pkg::CNT_W-1:0] cnt_new;
  rled_pkg::job_t             job_old, job_new;

  assign in_full = pend_r || q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    ext      = open_r && (in_item.in_byte == held_r);
    cnt_new  = ext ? rled_pkg::bcd_inc(cnt_r) : rled_pkg::CNT_W'(1);
    emit_old = open_r && !ext;
    emit_new = in_item.end_of_string || rled_pkg::bcd_full(cnt_new);

    job_old.run_byte      = held_r;
    job_old.count         = cnt_r;
    job_old.last_of_item  = !emit_new;
    job_old.end_of_output = 1'b0;

    job_new.run_byte      = in_item.in_byte;
    job_new.count         = cnt_new;
    job_new.last_of_item  = 1'b1;
    job_new.end_of_output = in_item.end_of_string;

    if (pend_r) begin
      q_push = !q_full;
      q_data = pend_job_r;
    end else begin
      q_push = accept && (emit_old || emit_new);
      q_data = emit_old ? job_old : job_new;
    end

    held_nxt     = held_r;
    open_nxt     = open_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r && q_full;
    pend_job_nxt = pend_job_r;
    if (accept) begin
      held_nxt = in_item.in_byte;
      open_nxt = !emit_new;
      cnt_nxt  = emit_new ? '0 : cnt_new;
      // two runs end on one item: the new one waits in the pending register
      if (emit_old && emit_new) begin
        pend_nxt     = 1'b1;
        pend_job_nxt = job_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      open_r <= 1'b0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      open_r <= open_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
  end

  `RLED_ASSERT_NEXT(a_pend_blocks_input, accept && emit_old && emit_new, in_full,
                    "front took an item while a second run was pending")

endmodule

// File: rtl/rled_queue.sv
// ----------------------------------------------------------------------------
// Run-length encoder job queue
// Short FIFO of finished runs between the front and back ends.
// ----------------------------------------------------------------------------
`include "run_length_encoder_decimal_defines.svh"

module rled_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rled_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output rled_pkg::job_t head,
  output logic           empty
);

  rled_pkg::job_t              mem_r [rled_pkg::QUEUE_DEPTH];
  logic [rled_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rled_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rled_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == rled_pkg::QCNT_W'(rled_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `RLED_ASSERT(a_no_overflow, !(push && full), "job queue written while full")
  `RLED_ASSERT(a_no_underflow, !(pop && empty), "job queue read while empty")

endmodule

// File: rtl/rled_back.sv
// ----------------------------------------------------------------------------
// Run-length encoder back end
// Writes each queued run out as its byte then its decimal digits.
// ----------------------------------------------------------------------------
`include "run_length_encoder_decimal_defines.svh"

module rled_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rled_pkg::job_t      head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output rled_pkg::out_item_t out_item
);

  logic                       busy_r, busy_nxt;
  rled_pkg::job_t             job_r, job_nxt;
  logic [rled_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  rled_pkg::out_item_t        out_r, out_nxt;

  logic                       adv, last_digit;
  logic [3:0]                 digit;
  rled_pkg::out_item_t        res;

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;
  // output register frees up this cycle
  assign adv       = !out_valid_r || out_pop;

  always_comb begin
    digit      = job_r.count[4*pos_r +: 4];
    if (digit > 4'd9) digit = 4'd9;
    last_digit = (pos_r == '0);
    q_pop      = 1'b0;
    res        = '0;
    busy_nxt   = busy_r;
    job_nxt    = job_r;
    pos_nxt    = pos_r;

    if (busy_r) begin
      res.out_byte      = rled_pkg::ASCII_ZERO + {4'd0, digit};
      res.last_of_item  = job_r.last_of_item && last_digit;
      res.end_of_output = job_r.end_of_output && last_digit;
      if (adv) begin
        busy_nxt = !last_digit;
        pos_nxt  = pos_r - 1'b1;
      end
    end else begin
      // run byte goes out in the cycle the job is taken
      res.out_byte = head.run_byte;
      if (adv && !q_empty) begin
        q_pop    = 1'b1;
        busy_nxt = 1'b1;
        job_nxt  = head;
        pos_nxt  = rled_pkg::bcd_top(head.count);
      end
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      out_valid_nxt = busy_r || !q_empty;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    pos_r <= pos_nxt;
    out_r <= out_nxt;
  end

  `RLED_ASSERT(a_busy_count_nonzero, !busy_r || (job_r.count != '0),
               "back end writing a run of length zero")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-length encoder testbench
// Sends byte strings through the encoder and checks every result against a
// run-length predictor: directed byte and count boundaries, random strings,
// output hold-off and drain pauses, with random idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 40000;
  localparam int FULL_LEN    = 10 ** rled_pkg::RUN_DIGITS - 1;

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  rled_pkg::in_item_t  in_item;
  logic                empty;
  logic                pop;
  rled_pkg::out_item_t out_item;

  run_length_encoder_decimal dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // predictor state
  logic [7:0]          run_byte_m;
  bit                  run_live;
  int                  run_len;
  rled_pkg::out_item_t item_results[$];
  rled_pkg::out_item_t encoded_q[$];
  rled_pkg::out_item_t want;

  int  errors;
  int  bytes_sent;
  int  chars_checked;
  int  stall_cycles;
  int  cycle_count;
  bit  tx_idle;
  bit  rx_idle;
  bit  hold_req;
  int  hold_len;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // appends the held run: run byte, then its decimal digits, msd first
  task automatic append_run();
    logic [7:0]          digits[$];
    rled_pkg::out_item_t r;
    int                  v;
    r = '0;
    r.out_byte = run_byte_m;
    item_results = {item_results, r};
    v = run_len;
    do begin
      digits.push_front(rled_pkg::ASCII_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v > 0);
    foreach (digits[i]) begin
      r.out_byte = digits[i];
      item_results = {item_results, r};
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input bit eos);
    rled_pkg::out_item_t r;
    int                  n;
    item_results.delete();
    if (run_live && b == run_byte_m) begin
      run_len++;
    end else begin
      if (run_live) append_run();
      run_byte_m = b;
      run_len    = 1;
      run_live   = 1'b1;
    end
    if (eos || run_len == FULL_LEN) begin
      append_run();
      run_live = 1'b0;
      run_len  = 0;
    end
    n = item_results.size();
    if (n > 0) begin
      r = item_results[n-1];
      r.last_of_item  = 1'b1;
      r.end_of_output = eos;
      item_results[n-1] = r;
    end
    encoded_q = {encoded_q, item_results};
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
    $display("mismatch on result %0d (%s): wanted %h, got %h, cycle %0d",
             chars_checked, field, exp_v, got_v, cycle_count);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && full) stall_cycles++;
      if (pop && !empty) begin
        if (encoded_q.size() == 0) begin
          report_mismatch("no result due", 8'h00, out_item.out_byte);
        end else begin
          want = encoded_q.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, out_item.out_byte);
          if (out_item.last_of_item !== want.last_of_item)
            report_mismatch("last_of_item", 8'(want.last_of_item),
                            8'(out_item.last_of_item));
          if (out_item.end_of_output !== want.end_of_output)
            report_mismatch("end_of_output", 8'(want.end_of_output),
                            8'(out_item.end_of_output));
        end
        chars_checked++;
      end
    end
  end

  // result side: random bursts of idling, plus a long hold-off on request
  initial begin : receiver
    int gap;
    int hold;
    gap = 0;
    hold = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold = hold_len;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 8) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // push stays high between back-to-back items; send_item lowers it only for a gap
  task automatic send_item(input logic [7:0] b, input bit eos);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= {b, eos};
    @(posedge clk);
    while (full) @(posedge clk);
    encode_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_run(input logic [7:0] b, input int len, input bit eos);
    for (int i = 0; i < len; i++) send_item(b, eos && (i == len - 1));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_byte_extremes();
    send_item(8'h41, 1'b1);           // one-byte string
    send_run(8'h00, 2, 1'b0);
    send_item(8'hFF, 1'b1);           // new byte on the last position
    send_run(8'hFF, 3, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b1);
    // same byte straight after a string end starts afresh
    send_item(8'hAA, 1'b0);
    send_item(8'hAA, 1'b1);
    send_item(8'h30, 1'b0);
    send_item(8'h39, 1'b0);
    send_run(8'h7F, 2, 1'b0);
    send_run(8'h80, 2, 1'b1);
  endtask

  task automatic test_count_widths();
    tx_idle = 1'b0;
    send_run(8'h61, 9, 1'b0);
    send_run(8'h62, 10, 1'b0);
    send_run(8'h63, 100, 1'b1);
    tx_idle = 1'b1;
  endtask

  task automatic test_output_hold_off();
    hold_len = 300;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(8'($urandom_range(0, 255)), i == 39);
  endtask

  task automatic test_drain_pause();
    for (int s = 0; s < 3; s++) begin
      send_run(8'($urandom_range(0, 255)), $urandom_range(1, 3), 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();
    end
  endtask

  task automatic test_random_strings(input int n_items);
    int         target;
    int         n_runs;
    int         len;
    logic [7:0] b;
    target = bytes_sent + n_items;
    while (bytes_sent < target) begin
      n_runs = $urandom_range(1, 5);
      for (int r = 0; r < n_runs; r++) begin
        // a small alphabet makes repeats across runs likely
        if ($urandom_range(0, 1) == 0) b = 8'h41 + 8'($urandom_range(0, 3));
        else b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) len = $urandom_range(8, 25);
        else len = $urandom_range(1, 3);
        send_run(b, len, r == n_runs - 1);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    run_byte_m = '0;
    run_live = 1'b0;
    run_len = 0;
    errors = 0;
    bytes_sent = 0;
    chars_checked = 0;
    stall_cycles = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    hold_len = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_byte_extremes();
    test_count_widths();
    test_output_hold_off();
    test_drain_pause();
    test_random_strings(60);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_strings(20);

    push <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Encoded %0d input bytes into %0d checked results;", bytes_sent, chars_checked);
    $display("counts of one to three digits, hold-off and drain pauses, %0d stalled cycles.",
             stall_cycles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
